@@ hw/rtl/u2u8_pkg.sv @@
// ----------------------------------------------------------------------------
// UTF-16 to UTF-8 transcoder package
// Shared constants, the queue entry type and the UTF-8 byte encoding helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package u2u8_pkg;

   localparam int CpWidth    = 21;
   localparam int QueueDepth = 2;
   localparam int QueuePtrW  = $clog2(QueueDepth);
   localparam int QueueCntW  = $clog2(QueueDepth + 1);

   localparam logic [5:0]         HighTag     = 6'b110110;
   localparam logic [5:0]         LowTag      = 6'b110111;
   localparam logic [CpWidth-1:0] Replacement = 21'h00FFFD;
   localparam logic [CpWidth-1:0] SuppBase    = 21'h010000;

   // One queue entry: an optional U+FFFD for a dropped high surrogate,
   // followed by an optional character, both caused by one transaction.
   typedef struct packed {
      logic               has_fill;
      logic               has_char;
      logic [CpWidth-1:0] cp;
      logic               last;
   } u2u8_entry_type;

   // Number of continuation bytes that follow the lead byte.
   function automatic logic [1:0] utf8_tail_count(input logic [CpWidth-1:0] cp);
      logic [1:0] n;
      if (cp[CpWidth-1:7] == '0) begin
         n = 2'd0;
      end else if (cp[CpWidth-1:11] == '0) begin
         n = 2'd1;
      end else if (cp[CpWidth-1:16] == '0) begin
         n = 2'd2;
      end else begin
         n = 2'd3;
      end
      return n;
   endfunction

   function automatic logic [7:0] utf8_byte_at(input logic [CpWidth-1:0] cp,
                                               input logic [1:0] idx);
      logic [1:0] n;
      logic [7:0] b;
      n = utf8_tail_count(cp);
      b = 8'h00;
      case (n)
         2'd0: b = {1'b0, cp[6:0]};
         2'd1: begin
            if (idx == 2'd0) b = {3'b110, cp[10:6]};
            else             b = {2'b10, cp[5:0]};
         end
         2'd2: begin
            case (idx)
               2'd0:    b = {4'b1110, cp[15:12]};
               2'd1:    b = {2'b10, cp[11:6]};
               default: b = {2'b10, cp[5:0]};
            endcase
         end
         default: begin
            case (idx)
               2'd0:    b = {5'b11110, cp[20:18]};
               2'd1:    b = {2'b10, cp[17:12]};
               2'd2:    b = {2'b10, cp[11:6]};
               default: b = {2'b10, cp[5:0]};
            endcase
         end
      endcase
      return b;
   endfunction

endpackage

`default_nettype wire

@@ hw/rtl/u2u8_if.sv @@
// ----------------------------------------------------------------------------
// UTF-16 to UTF-8 transcoder channel interfaces
// Valid/ready channels for incoming code units and outgoing UTF-8 bytes.
// ----------------------------------------------------------------------------
`default_nettype none

interface u2u8_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] code_unit;
   logic        last_unit;

   modport source (output valid, output code_unit, output last_unit, input ready);
   modport sink   (input valid, input code_unit, input last_unit, output ready);
endinterface

interface u2u8_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  utf8_byte;
   logic [20:0] code_point;
   logic        char_first;
   logic        run_last;
   logic        text_last;

   modport source (output valid, output utf8_byte, output code_point,
                   output char_first, output run_last, output text_last,
                   input ready);
   modport sink   (input valid, input utf8_byte, input code_point,
                   input char_first, input run_last, input text_last,
                   output ready);
endinterface

`default_nettype wire

@@ hw/rtl/utf16_to_utf8_transcoder.sv @@
// ----------------------------------------------------------------------------
// UTF-16 to UTF-8 transcoder
// Converts a stream of UTF-16 code units into tagged UTF-8 bytes.
//
// The req_ch channel takes one code unit per transaction, with last_unit set
// on the unit that ends the text. The rsp_ch channel gives one UTF-8 byte per
// transaction, with the code point it belongs to and flags for the first byte
// of a character, the last byte caused by a unit and the last byte of a text.
// A high surrogate that does not end the text is held until the next unit
// decides its fate; a bad surrogate comes out as U+FFFD. A unit causes up to
// six bytes. The first byte of a unit passes through the queue, the encoder's
// current character register and the output byte register. The encoder emits
// one byte per cycle while the receiver takes them; the front end accepts a
// new unit each cycle while the two-entry queue has room. When the receiver
// stalls, the output byte holds, the queue fills and req_ch.ready falls.
// Reset empties the queue and the encoder and drops any held high surrogate.
// ----------------------------------------------------------------------------
`default_nettype none

module utf16_to_utf8_transcoder
   import u2u8_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   u2u8_req_if.sink    req_ch,
   u2u8_rsp_if.source  rsp_ch
);

   logic           q_push;
   u2u8_entry_type q_push_entry;
   logic           q_full;
   logic           q_head_valid;
   u2u8_entry_type q_head_entry;
   logic           q_pop;

   u2u8_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .q_full  (q_full),
      .q_push  (q_push),
      .q_entry (q_push_entry)
   );

   u2u8_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_push_entry),
      .full       (q_full),
      .head_valid (q_head_valid),
      .head_entry (q_head_entry),
      .pop        (q_pop)
   );

   u2u8_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_head_valid),
      .q_entry (q_head_entry),
      .q_pop   (q_pop),
      .rsp_ch  (rsp_ch)
   );

endmodule

`default_nettype wire

@@ hw/rtl/u2u8_front.sv @@
// ----------------------------------------------------------------------------
// UTF-16 to UTF-8 transcoder front end
// Accepts code units, pairs surrogates and queues the characters to encode.
// ----------------------------------------------------------------------------
`default_nettype none

module u2u8_front
   import u2u8_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   u2u8_req_if.sink            req_ch,
   input  wire logic           q_full,
   output logic                q_push,
   output u2u8_entry_type      q_entry
);

   logic       held_valid_ff;
   logic       held_valid_in;
   logic [9:0] held_bits_ff;
   logic [9:0] held_bits_in;
   logic       fire;
   logic       is_high;
   logic       is_low;

   assign req_ch.ready = !q_full;
   assign fire         = req_ch.valid && req_ch.ready;
   assign is_high      = (req_ch.code_unit[15:10] == HighTag);
   assign is_low       = (req_ch.code_unit[15:10] == LowTag);

   always_comb begin
      q_push           = 1'b0;
      q_entry.has_fill = 1'b0;
      q_entry.has_char = 1'b0;
      q_entry.cp       = Replacement;
      q_entry.last     = req_ch.last_unit;
      held_valid_in    = held_valid_ff;
      held_bits_in     = held_bits_ff;
      if (fire) begin
         held_valid_in = 1'b0;
         held_bits_in  = '0;
         if (held_valid_ff && is_low) begin
            q_entry.has_char = 1'b1;
            q_entry.cp       = SuppBase + {1'b0, held_bits_ff, req_ch.code_unit[9:0]};
         end else begin
            q_entry.has_fill = held_valid_ff;
            if (is_high && !req_ch.last_unit) begin
               held_valid_in = 1'b1;
               held_bits_in  = req_ch.code_unit[9:0];
            end else begin
               q_entry.has_char = 1'b1;
               if (is_high || is_low) q_entry.cp = Replacement;
               else                   q_entry.cp = {5'b0, req_ch.code_unit};
            end
         end
         q_push = q_entry.has_fill || q_entry.has_char;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_valid_ff <= 1'b0;
         held_bits_ff  <= '0;
      end else begin
         held_valid_ff <= held_valid_in;
         held_bits_ff  <= held_bits_in;
      end
   end

endmodule

`default_nettype wire

@@ hw/rtl/u2u8_queue.sv @@
// ----------------------------------------------------------------------------
// UTF-16 to UTF-8 transcoder queue
// Short first-in first-out buffer between the front end and the encoder.
// ----------------------------------------------------------------------------
`default_nettype none

module u2u8_queue
   import u2u8_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           push,
   input  u2u8_entry_type      push_entry,
   output logic                full,
   output logic                head_valid,
   output u2u8_entry_type      head_entry,
   input  wire logic           pop
);

   u2u8_entry_type          slot_ff [QueueDepth];
   logic [QueuePtrW-1:0]    wr_ptr_ff;
   logic [QueuePtrW-1:0]    wr_ptr_in;
   logic [QueuePtrW-1:0]    rd_ptr_ff;
   logic [QueuePtrW-1:0]    rd_ptr_in;
   logic [QueueCntW-1:0]    count_ff;
   logic [QueueCntW-1:0]    count_in;

   assign full       = (count_ff == QueueCntW'(QueueDepth));
   assign head_valid = (count_ff != '0);
   assign head_entry = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QueuePtrW'(QueueDepth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QueuePtrW'(QueueDepth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

@@ hw/rtl/u2u8_back.sv @@
// ----------------------------------------------------------------------------
// UTF-16 to UTF-8 transcoder back end
// Expands queued characters into UTF-8 bytes, one byte per cycle while the receiver takes them.
// ----------------------------------------------------------------------------
`default_nettype none

module u2u8_back
   import u2u8_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           q_valid,
   input  u2u8_entry_type      q_entry,
   output logic                q_pop,
   u2u8_rsp_if.source          rsp_ch
);

   logic               cur_valid_ff;
   logic               cur_valid_in;
   logic               cur_fill_ff;
   logic               cur_fill_in;
   logic               cur_char_ff;
   logic               cur_char_in;
   logic [CpWidth-1:0] cur_cp_ff;
   logic [CpWidth-1:0] cur_cp_in;
   logic               cur_last_ff;
   logic               cur_last_in;
   logic [1:0]         idx_ff;
   logic [1:0]         idx_in;

   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   logic [7:0]         rsp_byte_ff;
   logic [CpWidth-1:0] rsp_cp_ff;
   logic               rsp_first_ff;
   logic               rsp_run_last_ff;
   logic               rsp_text_last_ff;

   logic [CpWidth-1:0] cp_sel;
   logic               char_end;
   logic               fill_then_char;
   logic               can_emit;
   logic               step;
   logic               done;

   assign cp_sel         = cur_fill_ff ? Replacement : cur_cp_ff;
   assign char_end       = (idx_ff == utf8_tail_count(cp_sel));
   assign fill_then_char = cur_fill_ff && cur_char_ff;
   assign can_emit       = !rsp_valid_ff || rsp_ch.ready;
   assign step           = cur_valid_ff && can_emit;
   assign done           = step && char_end && !fill_then_char;
   assign q_pop          = q_valid && (!cur_valid_ff || done);

   always_comb begin
      cur_valid_in = cur_valid_ff;
      cur_fill_in  = cur_fill_ff;
      cur_char_in  = cur_char_ff;
      cur_cp_in    = cur_cp_ff;
      cur_last_in  = cur_last_ff;
      idx_in       = idx_ff;
      if (q_pop) begin
         cur_valid_in = 1'b1;
         cur_fill_in  = q_entry.has_fill;
         cur_char_in  = q_entry.has_char;
         cur_cp_in    = q_entry.cp;
         cur_last_in  = q_entry.last;
         idx_in       = '0;
      end else if (done) begin
         cur_valid_in = 1'b0;
      end else if (step) begin
         if (char_end) begin
            cur_fill_in = 1'b0;
            idx_in      = '0;
         end else begin
            idx_in = idx_ff + 1'b1;
         end
      end
      rsp_valid_in = can_emit ? cur_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_fill_ff <= cur_fill_in;
      cur_char_ff <= cur_char_in;
      cur_cp_ff   <= cur_cp_in;
      cur_last_ff <= cur_last_in;
      idx_ff      <= idx_in;
      if (step) begin
         rsp_byte_ff      <= utf8_byte_at(cp_sel, idx_ff);
         rsp_cp_ff        <= cp_sel;
         rsp_first_ff     <= (idx_ff == 2'd0);
         rsp_run_last_ff  <= char_end && !fill_then_char;
         rsp_text_last_ff <= char_end && !fill_then_char && cur_last_ff;
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.utf8_byte  = rsp_byte_ff;
   assign rsp_ch.code_point = rsp_cp_ff;
   assign rsp_ch.char_first = rsp_first_ff;
   assign rsp_ch.run_last   = rsp_run_last_ff;
   assign rsp_ch.text_last  = rsp_text_last_ff;

endmodule

`default_nettype wire

@@ hw/rtl/u2u8_checker.sv @@
// ----------------------------------------------------------------------------
// UTF-16 to UTF-8 transcoder checker
// Port-level assertions on the byte stream, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module u2u8_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_ready,
   input  wire logic [7:0]  rsp_byte,
   input  wire logic [20:0] rsp_cp,
   input  wire logic        rsp_first,
   input  wire logic        rsp_run_last,
   input  wire logic        rsp_text_last
);

   // A stalled byte stays in place.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_byte) && $stable(rsp_cp))
      else $error("stalled transaction changed");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_first |-> rsp_byte[7:6] != 2'b10)
      else $error("first byte is a continuation byte");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_first |-> rsp_byte[7:6] == 2'b10)
      else $error("later byte is not a continuation byte");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_text_last |-> rsp_run_last)
      else $error("end of text not at end of a unit");

   // Surrogate code points never leave the block.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_cp[20:11] != 10'b0000011011)
      else $error("surrogate code point emitted");

endmodule

bind utf16_to_utf8_transcoder u2u8_checker u_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .rsp_byte      (rsp_ch.utf8_byte),
   .rsp_cp        (rsp_ch.code_point),
   .rsp_first     (rsp_ch.char_first),
   .rsp_run_last  (rsp_ch.run_last),
   .rsp_text_last (rsp_ch.text_last)
);

`default_nettype wire
